// File: sv/lom_pkg.sv
package lom_pkg;

  // Book geometry
  localparam int ORDERS     = 1024;
  localparam int ID_W       = 10;
  localparam int LINK_W     = ID_W + 1;   // top bit set means no link
  localparam int QTY_W      = 24;
  localparam int PRICE_W    = 10;
  localparam int ROW_W      = 5;          // busy bitmap row select
  localparam int COL_W      = PRICE_W - ROW_W;
  localparam int ROWS       = 1 << ROW_W;
  localparam int COLS       = 1 << COL_W;
  localparam int CNT_W      = 11;
  localparam int FILL_W     = 6;
  localparam int MAX_FILLS_DEF = 63;
  localparam int CMD_DEPTH  = 2;
  localparam int RES_DEPTH  = 2;

  localparam logic [LINK_W-1:0] LINK_NONE = LINK_W'(ORDERS);

  typedef enum logic { OP_ADD = 1'b0, OP_CANCEL = 1'b1 } op_t;
  typedef enum logic { SIDE_BID = 1'b0, SIDE_ASK = 1'b1 } side_t;
  typedef enum logic { KIND_FILL = 1'b0, KIND_SUMMARY = 1'b1 } kind_t;
  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_NOT_FOUND = 2'd1,
    ST_LIVE      = 2'd2,
    ST_LIMIT     = 2'd3
  } status_t;

  // Classified command handed from the front to the matching engine
  typedef struct packed {
    op_t                op;
    side_t              side;
    logic [ID_W-1:0]    order_id;
    logic [QTY_W-1:0]   quantity;
    logic [PRICE_W-1:0] price;
    logic               qty_zero;
  } cmd_t;

  // One order table entry
  typedef struct packed {
    logic               live;
    side_t              side;
    logic [PRICE_W-1:0] price;
    logic [QTY_W-1:0]   qty;
    logic [LINK_W-1:0]  next;
    logic [LINK_W-1:0]  prev;
  } entry_t;

  // One price level FIFO
  typedef struct packed {
    logic [LINK_W-1:0] head;
    logic [LINK_W-1:0] tail;
  } level_t;

  typedef struct packed {
    kind_t              kind;
    logic [QTY_W-1:0]   fill_quantity;
    logic [PRICE_W-1:0] fill_price;
    logic [ID_W-1:0]    resting_order_id;
    logic [QTY_W-1:0]   remaining_quantity;
    status_t            status;
    logic signed [CNT_W-1:0] spread;
    logic [CNT_W-1:0]   waiting_bids;
    logic [CNT_W-1:0]   waiting_asks;
    logic               last;
  } result_t;

  // Highest set bit of a bitmap row
  function automatic logic [COL_W-1:0] hi_bit(input logic [COLS-1:0] v);
    logic [COL_W-1:0] r;
    r = '0;
    for (int i = 0; i < COLS; i++) begin
      if (v[i]) r = COL_W'(i);
    end
    return r;
  endfunction

  // Lowest set bit of a bitmap row
  function automatic logic [COL_W-1:0] lo_bit(input logic [COLS-1:0] v);
    logic [COL_W-1:0] r;
    r = '0;
    for (int i = COLS - 1; i >= 0; i--) begin
      if (v[i]) r = COL_W'(i);
    end
    return r;
  endfunction

endpackage

// File: sv/limit_order_matcher_unit.sv
// Price-time priority limit order book. Orders enter through a queue-style
// port (push/full) and results leave through one (pop/empty): each add gives
// one fill transaction per trade, oldest resting order at the best opposite
// price first, then one summary transaction (last=1) with remaining quantity,
// status, spread and resting counts; a cancel gives only the summary. After
// reset the order table is swept clear before the first item is taken.
// Items are worked one at a time by a sequencer over order, level and
// price-bitmap memories with one read and one write port each: lookup and
// best-price search per item, plus a fill step per trade, an unlink per
// order removed from the book and a link to rest the remainder. The best
// price is found from a row summary register and one bitmap word read.
module limit_order_matcher_unit #(
  parameter int MAX_FILLS = lom_pkg::MAX_FILLS_DEF
) (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               push,
  output logic                               full,
  input  logic                               op,
  input  logic                               side,
  input  logic [lom_pkg::ID_W-1:0]           order_id,
  input  logic [lom_pkg::QTY_W-1:0]          quantity,
  input  logic [lom_pkg::PRICE_W-1:0]        price,
  output logic                               empty,
  input  logic                               pop,
  output logic                               kind,
  output logic [lom_pkg::QTY_W-1:0]          fill_quantity,
  output logic [lom_pkg::PRICE_W-1:0]        fill_price,
  output logic [lom_pkg::ID_W-1:0]           resting_order_id,
  output logic [lom_pkg::QTY_W-1:0]          remaining_quantity,
  output logic [1:0]                         status,
  output logic signed [lom_pkg::CNT_W-1:0]   spread,
  output logic [lom_pkg::CNT_W-1:0]          waiting_bids,
  output logic [lom_pkg::CNT_W-1:0]          waiting_asks,
  output logic                               last
);
  import lom_pkg::*;

  cmd_t    f_cmd;
  logic    f_push;
  logic    f_full;
  cmd_t    q_cmd;
  logic    q_empty;
  logic    q_pop;
  result_t e_res;
  logic    e_push;
  logic    e_full;
  result_t o_res;

  lom_front u_front (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .full     (full),
    .op       (op),
    .side     (side),
    .order_id (order_id),
    .quantity (quantity),
    .price    (price),
    .cmd      (f_cmd),
    .cmd_push (f_push),
    .cmd_full (f_full)
  );

  // Command queue between front and engine
  lom_fifo #(.T(cmd_t), .DEPTH(CMD_DEPTH)) u_cmd_q (
    .clk   (clk),
    .rst   (rst),
    .push  (f_push),
    .din   (f_cmd),
    .full  (f_full),
    .pop   (q_pop),
    .dout  (q_cmd),
    .empty (q_empty)
  );

  lom_engine #(.MAX_FILLS(MAX_FILLS)) u_engine (
    .clk       (clk),
    .rst       (rst),
    .cmd       (q_cmd),
    .cmd_empty (q_empty),
    .cmd_pop   (q_pop),
    .res       (e_res),
    .res_push  (e_push),
    .res_full  (e_full)
  );

  // Result queue
  lom_fifo #(.T(result_t), .DEPTH(RES_DEPTH)) u_res_q (
    .clk   (clk),
    .rst   (rst),
    .push  (e_push),
    .din   (e_res),
    .full  (e_full),
    .pop   (pop),
    .dout  (o_res),
    .empty (empty)
  );

  assign kind               = o_res.kind;
  assign fill_quantity      = o_res.fill_quantity;
  assign fill_price         = o_res.fill_price;
  assign resting_order_id   = o_res.resting_order_id;
  assign remaining_quantity = o_res.remaining_quantity;
  assign status             = o_res.status;
  assign spread             = o_res.spread;
  assign waiting_bids       = o_res.waiting_bids;
  assign waiting_asks       = o_res.waiting_asks;
  assign last               = o_res.last;
endmodule

// File: sv/lom_fifo.sv
module lom_fifo #(
  parameter type T = logic,
  parameter int DEPTH = 2
) (
  input  logic clk,
  input  logic rst,
  input  logic push,
  input  T     din,
  output logic full,
  input  logic pop,
  output T     dout,
  output logic empty
);
  localparam int AW = $clog2(DEPTH);

  T               slots [DEPTH];
  logic [AW-1:0]  wp;
  logic [AW-1:0]  rp;
  logic [AW:0]    cnt;
  logic           do_push;
  logic           do_pop;

  assign full    = (cnt == (AW+1)'(DEPTH));
  assign empty   = (cnt == '0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign dout    = slots[rp];

  // Storage
  always_ff @(posedge clk) begin
    if (do_push) slots[wp] <= din;
  end

  // Pointers and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      wp  <= '0;
      rp  <= '0;
      cnt <= '0;
    end else begin
      if (do_push) wp <= (wp == AW'(DEPTH - 1)) ? '0 : wp + 1'b1;
      if (do_pop)  rp <= (rp == AW'(DEPTH - 1)) ? '0 : rp + 1'b1;
      if (do_push && !do_pop) cnt <= cnt + 1'b1;
      else if (do_pop && !do_push) cnt <= cnt - 1'b1;
    end
  end
endmodule

// File: sv/lom_front.sv
module lom_front (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         push,
  output logic                         full,
  input  logic                         op,
  input  logic                         side,
  input  logic [lom_pkg::ID_W-1:0]     order_id,
  input  logic [lom_pkg::QTY_W-1:0]    quantity,
  input  logic [lom_pkg::PRICE_W-1:0]  price,
  output lom_pkg::cmd_t                cmd,
  output logic                         cmd_push,
  input  logic                         cmd_full
);
  import lom_pkg::*;

  logic slot_valid;
  cmd_t slot;
  logic take;

  assign full     = slot_valid && cmd_full;
  assign take     = push && !full;
  assign cmd_push = slot_valid && !cmd_full;
  assign cmd      = slot;

  // Input stage: capture and classify the transaction
  always_ff @(posedge clk) begin
    if (rst) begin
      slot_valid <= 1'b0;
    end else if (take) begin
      slot_valid <= 1'b1;
    end else if (cmd_push) begin
      slot_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      slot.op       <= op_t'(op);
      slot.side     <= side_t'(side);
      slot.order_id <= order_id;
      slot.quantity <= quantity;
      slot.price    <= price;
      slot.qty_zero <= (quantity == '0);
    end
  end
endmodule

// File: sv/lom_engine.sv
module lom_engine #(
  parameter int MAX_FILLS = lom_pkg::MAX_FILLS_DEF
) (
  input  logic             clk,
  input  logic             rst,
  input  lom_pkg::cmd_t    cmd,
  input  logic             cmd_empty,
  output logic             cmd_pop,
  output lom_pkg::result_t res,
  output logic             res_push,
  input  logic             res_full
);
  import lom_pkg::*;

  typedef enum logic [18:0] {
    S_CLR   = 19'h00001,
    S_IDLE  = 19'h00002,
    S_FETCH = 19'h00004,
    S_LOOK  = 19'h00008,
    S_SR0   = 19'h00010,
    S_SR1   = 19'h00020,
    S_M0    = 19'h00040,
    S_M1    = 19'h00080,
    S_M2    = 19'h00100,
    S_U0    = 19'h00200,
    S_U1    = 19'h00400,
    S_U2    = 19'h00800,
    S_U3    = 19'h01000,
    S_U4    = 19'h02000,
    S_U5    = 19'h04000,
    S_A0    = 19'h08000,
    S_A1    = 19'h10000,
    S_A2    = 19'h20000,
    S_A3    = 19'h40000
  } state_t;

  // Where a finished best-price search continues
  typedef enum logic [1:0] { RET_MATCH = 2'd0, RET_BID = 2'd1, RET_ASK = 2'd2 } ret_t;

  state_t state;
  logic   in_sum;        // summary emit step, entered from any flow

  // Memories
  entry_t              ent_mem [ORDERS];
  entry_t              ent_rd;
  logic                ent_we;
  logic [ID_W-1:0]     ent_wa;
  logic [ID_W-1:0]     ent_ra;
  entry_t              ent_wd;

  level_t              lvl_mem [2*ORDERS];
  level_t              lvl_rd;
  logic                lvl_we;
  logic [ID_W:0]       lvl_wa;
  logic [ID_W:0]       lvl_ra;
  level_t              lvl_wd;

  logic [COLS-1:0]     busy_mem [2*ROWS];
  logic [COLS-1:0]     busy_rd;
  logic                busy_we;
  logic [ROW_W:0]      busy_wa;
  logic [ROW_W:0]      busy_ra;
  logic [COLS-1:0]     busy_wd;

  // Control and working registers
  logic [ID_W-1:0]     clr_cnt;
  cmd_t                cmd_q;
  logic [ID_W-1:0]     cur_id;
  entry_t              cur_e;
  logic [QTY_W-1:0]    rem;
  logic [FILL_W-1:0]   nfill;
  status_t             status_q;
  side_t               srch_side;
  ret_t                srch_ret;
  logic [ROW_W-1:0]    srch_row;
  logic [PRICE_W-1:0]  bp;
  logic                hb;
  logic                ha;
  logic [PRICE_W-1:0]  bb;
  logic [PRICE_W-1:0]  ba;
  logic                ul_match;
  logic [1:0][ROWS-1:0] row_busy;   // nonempty rows; a clear bit means the row reads zero
  logic [CNT_W-1:0]    bid_total;
  logic [CNT_W-1:0]    ask_total;

  // Helpers
  side_t               opp;
  logic [ROWS-1:0]     sum_sel;
  logic [ROW_W-1:0]    row_pick;
  logic [COL_W-1:0]    col_pick;
  logic                srch_done;
  logic                srch_found;
  logic [PRICE_W-1:0]  srch_price;
  logic                crosses;
  logic [QTY_W-1:0]    fq;
  entry_t              ent_upd;
  level_t              lvl_new;
  logic [COLS-1:0]     ul_word;
  logic [COLS-1:0]     ap_word;
  logic                ap_busy;
  logic                emit_fill;
  logic                emit_sum;
  logic [CNT_W-1:0]    diff;

  // Memory ports
  always_ff @(posedge clk) begin
    if (ent_we) ent_mem[ent_wa] <= ent_wd;
    ent_rd <= ent_mem[ent_ra];
  end

  always_ff @(posedge clk) begin
    if (lvl_we) lvl_mem[lvl_wa] <= lvl_wd;
    lvl_rd <= lvl_mem[lvl_ra];
  end

  always_ff @(posedge clk) begin
    if (busy_we) busy_mem[busy_wa] <= busy_wd;
    busy_rd <= busy_mem[busy_ra];
  end

  // Search, fill and link arithmetic
  always_comb begin
    opp        = side_t'(~cmd_q.side);
    sum_sel    = row_busy[srch_side];
    row_pick   = (srch_side == SIDE_ASK) ? lo_bit(sum_sel) : hi_bit(sum_sel);
    col_pick   = (srch_side == SIDE_ASK) ? lo_bit(busy_rd) : hi_bit(busy_rd);
    srch_done  = (state == S_SR1) || ((state == S_SR0) && (sum_sel == '0));
    srch_found = (state == S_SR1);
    srch_price = {srch_row, col_pick};
    crosses    = (cmd_q.side == SIDE_ASK) ? (srch_price >= cmd_q.price)
                                          : (srch_price <= cmd_q.price);

    fq         = (ent_rd.qty < rem) ? ent_rd.qty : rem;
    ent_upd    = ent_rd;
    ent_upd.qty = ent_rd.qty - fq;

    lvl_new = lvl_rd;
    if (cur_e.prev[LINK_W-1]) lvl_new.head = cur_e.next;
    if (cur_e.next[LINK_W-1]) lvl_new.tail = cur_e.prev;
    ul_word = (row_busy[cur_e.side][cur_e.price[PRICE_W-1:COL_W]] ? busy_rd : '0)
              & ~(COLS'(1) << cur_e.price[COL_W-1:0]);

    ap_word = row_busy[cmd_q.side][cmd_q.price[PRICE_W-1:COL_W]] ? busy_rd : '0;
    ap_busy = ap_word[cmd_q.price[COL_W-1:0]];

    emit_fill = (state == S_M2) && !res_full;
    emit_sum  = in_sum && !res_full;
    diff      = {1'b0, ba} - {1'b0, bb};
  end

  // Memory addresses and write data
  always_comb begin
    ent_we  = 1'b0;
    ent_wa  = cur_id;
    ent_wd  = ent_rd;
    ent_ra  = cmd_q.order_id;
    lvl_we  = 1'b0;
    lvl_wa  = {cur_e.side, cur_e.price};
    lvl_wd  = lvl_new;
    lvl_ra  = {cur_e.side, cur_e.price};
    busy_we = 1'b0;
    busy_wa = {cur_e.side, cur_e.price[PRICE_W-1:COL_W]};
    busy_wd = ul_word;
    busy_ra = {cur_e.side, cur_e.price[PRICE_W-1:COL_W]};
    case (state)
      S_CLR: begin
        ent_we = 1'b1;
        ent_wa = clr_cnt;
        ent_wd = '0;
      end
      S_FETCH: ent_ra = cmd_q.order_id;
      S_SR0:   busy_ra = {srch_side, row_pick};
      S_M0:    lvl_ra = {opp, bp};
      S_M1:    ent_ra = lvl_rd.head[ID_W-1:0];
      S_M2: begin
        // Keep the resting entry on the read port while the fill waits
        ent_ra = cur_id;
        ent_we = !res_full;
        ent_wd = ent_upd;
      end
      S_U1: begin
        ent_we      = 1'b1;
        ent_wd      = cur_e;
        ent_wd.live = 1'b0;
        lvl_we      = 1'b1;
        busy_we     = lvl_new.head[LINK_W-1];
      end
      S_U2: ent_ra = cur_e.prev[ID_W-1:0];
      S_U3: begin
        ent_we      = 1'b1;
        ent_wa      = cur_e.prev[ID_W-1:0];
        ent_wd.next = cur_e.next;
      end
      S_U4: ent_ra = cur_e.next[ID_W-1:0];
      S_U5: begin
        ent_we      = !cur_e.next[LINK_W-1];
        ent_wa      = cur_e.next[ID_W-1:0];
        ent_wd.prev = cur_e.prev;
      end
      S_A0: begin
        lvl_ra  = {cmd_q.side, cmd_q.price};
        busy_ra = {cmd_q.side, cmd_q.price[PRICE_W-1:COL_W]};
      end
      S_A1: begin
        ent_we       = 1'b1;
        ent_wa       = cmd_q.order_id;
        ent_wd.live  = 1'b1;
        ent_wd.side  = cmd_q.side;
        ent_wd.price = cmd_q.price;
        ent_wd.qty   = rem;
        ent_wd.next  = LINK_NONE;
        ent_wd.prev  = ap_busy ? lvl_rd.tail : LINK_NONE;
        lvl_we       = 1'b1;
        lvl_wa       = {cmd_q.side, cmd_q.price};
        lvl_wd.head  = ap_busy ? lvl_rd.head : {1'b0, cmd_q.order_id};
        lvl_wd.tail  = {1'b0, cmd_q.order_id};
        busy_we      = !ap_busy;
        busy_wa      = {cmd_q.side, cmd_q.price[PRICE_W-1:COL_W]};
        busy_wd      = ap_word | (COLS'(1) << cmd_q.price[COL_W-1:0]);
      end
      S_A2: ent_ra = cur_id;
      S_A3: begin
        ent_we      = 1'b1;
        ent_wa      = cur_id;
        ent_wd.next = {1'b0, cmd_q.order_id};
      end
      default: ;
    endcase
  end

  // Sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_CLR;
      in_sum    <= 1'b0;
      clr_cnt   <= '0;
      row_busy  <= '0;
      bid_total <= '0;
      ask_total <= '0;
    end else if (in_sum) begin
      if (!res_full) begin
        in_sum <= 1'b0;
        state  <= S_IDLE;
      end
    end else begin
      case (state)
        S_CLR: begin
          clr_cnt <= clr_cnt + 1'b1;
          if (clr_cnt == ID_W'(ORDERS - 1)) state <= S_IDLE;
        end
        S_IDLE: begin
          if (!cmd_empty) begin
            cmd_q <= cmd;
            state <= S_FETCH;
          end
        end
        S_FETCH: state <= S_LOOK;
        S_LOOK: begin
          nfill     <= '0;
          status_q  <= ST_OK;
          rem       <= '0;
          srch_side <= SIDE_BID;
          srch_ret  <= RET_BID;
          state     <= S_SR0;
          if (cmd_q.op == OP_CANCEL) begin
            if (ent_rd.live) begin
              cur_id   <= cmd_q.order_id;
              cur_e    <= ent_rd;
              ul_match <= 1'b0;
              state    <= S_U0;
            end else begin
              status_q <= ST_NOT_FOUND;
            end
          end else if (ent_rd.live) begin
            status_q <= ST_LIVE;
          end else begin
            rem <= cmd_q.quantity;
            if (!cmd_q.qty_zero) begin
              srch_side <= opp;
              srch_ret  <= RET_MATCH;
            end
          end
        end
        S_SR0, S_SR1: begin
          if (!srch_done) begin
            srch_row <= row_pick;
            state    <= S_SR1;
          end else begin
            case (srch_ret)
              RET_MATCH: begin
                state <= S_A0;
                if (srch_found && crosses) begin
                  if (nfill >= FILL_W'(MAX_FILLS)) begin
                    status_q <= ST_LIMIT;
                  end else begin
                    bp    <= srch_price;
                    state <= S_M0;
                  end
                end
              end
              RET_BID: begin
                hb        <= srch_found;
                bb        <= srch_price;
                srch_side <= SIDE_ASK;
                srch_ret  <= RET_ASK;
                state     <= S_SR0;
              end
              default: begin
                ha     <= srch_found;
                ba     <= srch_price;
                in_sum <= 1'b1;
              end
            endcase
          end
        end
        S_M0: state <= S_M1;
        S_M1: begin
          cur_id <= lvl_rd.head[ID_W-1:0];
          state  <= S_M2;
        end
        S_M2: begin
          if (!res_full) begin
            rem   <= rem - fq;
            nfill <= nfill + 1'b1;
            cur_e <= ent_upd;
            if (ent_upd.qty == '0) begin
              ul_match <= 1'b1;
              state    <= S_U0;
            end else begin
              srch_side <= SIDE_BID;
              srch_ret  <= RET_BID;
              state     <= S_SR0;
            end
          end
        end
        S_U0: state <= S_U1;
        S_U1: begin
          if (lvl_new.head[LINK_W-1]) begin
            row_busy[cur_e.side][cur_e.price[PRICE_W-1:COL_W]] <= |ul_word;
          end
          if (cur_e.side == SIDE_ASK) begin
            if (ask_total != '0) ask_total <= ask_total - 1'b1;
          end else begin
            if (bid_total != '0) bid_total <= bid_total - 1'b1;
          end
          if (!cur_e.prev[LINK_W-1]) begin
            state <= S_U2;
          end else if (!cur_e.next[LINK_W-1]) begin
            state <= S_U4;
          end else begin
            state <= S_U5;
          end
        end
        S_U2: state <= S_U3;
        S_U3: state <= cur_e.next[LINK_W-1] ? S_U5 : S_U4;
        S_U4: state <= S_U5;
        S_U5: begin
          // Unlink finished; the next neighbor is patched only when it exists
          srch_side <= SIDE_BID;
          srch_ret  <= RET_BID;
          state     <= S_SR0;
          if (ul_match && rem != '0) begin
            srch_side <= opp;
            srch_ret  <= RET_MATCH;
          end
        end
        S_A0: state <= S_A1;
        S_A1: begin
          if (cmd_q.side == SIDE_ASK) ask_total <= ask_total + 1'b1;
          else bid_total <= bid_total + 1'b1;
          if (!ap_busy) begin
            row_busy[cmd_q.side][cmd_q.price[PRICE_W-1:COL_W]] <= 1'b1;
          end
          cur_id <= lvl_rd.tail[ID_W-1:0];
          if (ap_busy) begin
            state <= S_A2;
          end else begin
            srch_side <= SIDE_BID;
            srch_ret  <= RET_BID;
            state     <= S_SR0;
          end
        end
        S_A2: state <= S_A3;
        S_A3: begin
          srch_side <= SIDE_BID;
          srch_ret  <= RET_BID;
          state     <= S_SR0;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // Result transactions
  assign cmd_pop  = (state == S_IDLE) && !in_sum && !rst && !cmd_empty;
  assign res_push = (emit_fill && !in_sum) || emit_sum;

  always_comb begin
    res = '0;
    if (in_sum) begin
      res.kind               = KIND_SUMMARY;
      res.remaining_quantity = rem;
      res.status             = status_q;
      res.spread             = (hb && ha) ? diff : '1;
      res.waiting_bids       = bid_total;
      res.waiting_asks       = ask_total;
      res.last               = 1'b1;
    end else begin
      res.kind               = KIND_FILL;
      res.fill_quantity      = fq;
      res.fill_price         = bp;
      res.resting_order_id   = cur_id;
      res.remaining_quantity = rem - fq;
      res.status             = ST_OK;
    end
  end
endmodule

// File: tb/lom_checker.sv
module lom_checker (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             push,
  input  logic                             full,
  input  logic                             op,
  input  logic                             side,
  input  logic [lom_pkg::ID_W-1:0]         order_id,
  input  logic [lom_pkg::QTY_W-1:0]        quantity,
  input  logic [lom_pkg::PRICE_W-1:0]      price,
  input  logic                             empty,
  input  logic                             pop,
  input  logic                             kind,
  input  logic [lom_pkg::QTY_W-1:0]        fill_quantity,
  input  logic [lom_pkg::PRICE_W-1:0]      fill_price,
  input  logic [lom_pkg::ID_W-1:0]         resting_order_id,
  input  logic [lom_pkg::QTY_W-1:0]        remaining_quantity,
  input  logic [1:0]                       status,
  input  logic signed [lom_pkg::CNT_W-1:0] spread,
  input  logic [lom_pkg::CNT_W-1:0]        waiting_bids,
  input  logic [lom_pkg::CNT_W-1:0]        waiting_asks,
  input  logic                             last,
  output int                               errors,
  output int                               pending
);
  import lom_pkg::*;

  localparam int LEVELS = 1 << PRICE_W;

  // Shadow book
  logic [QTY_W-1:0]   bk_qty [ORDERS];
  logic [PRICE_W-1:0] bk_price [ORDERS];
  side_t              bk_side [ORDERS];
  logic               bk_live [ORDERS];
  int                 bk_next [ORDERS];
  int                 bk_prev [ORDERS];
  int                 lvl_head [2][LEVELS];
  int                 lvl_tail [2][LEVELS];
  logic               lvl_busy [2][LEVELS];
  logic [CNT_W-1:0]   n_resting [2];

  result_t trade_reports [$];

  assign pending = trade_reports.size();

  function automatic bit best_level(input side_t s, output int p);
    p = 0;
    if (s == SIDE_ASK) begin
      for (int i = 0; i < LEVELS; i++)
        if (lvl_busy[1][i]) begin p = i; return 1; end
    end else begin
      for (int i = LEVELS - 1; i >= 0; i--)
        if (lvl_busy[0][i]) begin p = i; return 1; end
    end
    return 0;
  endfunction

  function automatic void remove_order(input int id);
    int s, p, pv, nx;
    s = bk_side[id];
    p = bk_price[id];
    pv = bk_prev[id];
    nx = bk_next[id];
    if (pv >= ORDERS) lvl_head[s][p] = nx; else bk_next[pv] = nx;
    if (nx >= ORDERS) lvl_tail[s][p] = pv; else bk_prev[nx] = pv;
    if (lvl_head[s][p] >= ORDERS) lvl_busy[s][p] = 0;
    bk_live[id] = 0;
    if (n_resting[s] != 0) n_resting[s]--;
  endfunction

  function automatic void rest_order(input int id, input side_t s, input int p,
                                     input logic [QTY_W-1:0] q);
    bk_qty[id] = q;
    bk_price[id] = PRICE_W'(p);
    bk_side[id] = s;
    bk_next[id] = ORDERS;
    if (lvl_busy[s][p]) begin
      bk_prev[id] = lvl_tail[s][p];
      bk_next[lvl_tail[s][p]] = id;
    end else begin
      bk_prev[id] = ORDERS;
      lvl_head[s][p] = id;
      lvl_busy[s][p] = 1;
    end
    lvl_tail[s][p] = id;
    bk_live[id] = 1;
    n_resting[s]++;
  endfunction

  // Match one incoming transaction and queue the reports it causes
  function automatic void match_order(input op_t o, input side_t s, input int id,
                                      input logic [QTY_W-1:0] q, input int p);
    result_t r;
    logic [QTY_W-1:0] rem, fq;
    status_t st;
    int nf, bp, bb, ba, rid;
    bit hb, ha;
    side_t opp;
    rem = 0;
    st = ST_OK;
    nf = 0;
    if (o == OP_CANCEL) begin
      if (bk_live[id]) remove_order(id); else st = ST_NOT_FOUND;
    end else if (bk_live[id]) begin
      st = ST_LIVE;
    end else begin
      opp = side_t'(~s);
      rem = q;
      while (rem > 0 && best_level(opp, bp) &&
             (s == SIDE_ASK ? bp >= p : bp <= p)) begin
        if (nf >= MAX_FILLS_DEF) begin st = ST_LIMIT; break; end
        rid = lvl_head[opp][bp];
        fq = bk_qty[rid] < rem ? bk_qty[rid] : rem;
        bk_qty[rid] -= fq;
        rem -= fq;
        r = '0;
        r.kind = KIND_FILL;
        r.fill_quantity = fq;
        r.fill_price = PRICE_W'(bp);
        r.resting_order_id = ID_W'(rid);
        r.remaining_quantity = rem;
        trade_reports.insert(trade_reports.size(), r);
        nf++;
        if (bk_qty[rid] == 0) remove_order(rid);
      end
      if (rem > 0) rest_order(id, s, p, rem);
    end
    hb = best_level(SIDE_BID, bb);
    ha = best_level(SIDE_ASK, ba);
    r = '0;
    r.kind = KIND_SUMMARY;
    r.remaining_quantity = rem;
    r.status = st;
    r.spread = (hb && ha) ? CNT_W'(ba - bb) : -11'sd1;
    r.waiting_bids = n_resting[0];
    r.waiting_asks = n_resting[1];
    r.last = 1;
    trade_reports.insert(trade_reports.size(), r);
  endfunction

  always @(posedge clk) begin
    result_t e;
    if (rst) begin
      errors <= 0;
      trade_reports.delete();
      for (int i = 0; i < ORDERS; i++) bk_live[i] = 0;
      for (int i = 0; i < LEVELS; i++) begin
        lvl_busy[0][i] = 0;
        lvl_busy[1][i] = 0;
      end
      n_resting[0] = 0;
      n_resting[1] = 0;
    end else begin
      // Compare the result transaction before predicting the new input
      if (pop && !empty) begin
        if (trade_reports.size() == 0) begin
          $error("unexpected result transaction");
          errors <= errors + 1;
        end else begin
          e = trade_reports.pop_front();
          if (kind !== e.kind ||
              fill_quantity !== e.fill_quantity ||
              fill_price !== e.fill_price ||
              resting_order_id !== e.resting_order_id ||
              remaining_quantity !== e.remaining_quantity ||
              status !== e.status || spread !== e.spread ||
              waiting_bids !== e.waiting_bids ||
              waiting_asks !== e.waiting_asks || last !== e.last)
            errors <= errors + 1;
          if (kind !== e.kind)
            $error("kind exp %0d got %0d", e.kind, kind);
          if (fill_quantity !== e.fill_quantity)
            $error("fill_quantity exp %0d got %0d", e.fill_quantity, fill_quantity);
          if (fill_price !== e.fill_price)
            $error("fill_price exp %0d got %0d", e.fill_price, fill_price);
          if (resting_order_id !== e.resting_order_id)
            $error("resting_order_id exp %0d got %0d", e.resting_order_id,
                   resting_order_id);
          if (remaining_quantity !== e.remaining_quantity)
            $error("remaining_quantity exp %0d got %0d", e.remaining_quantity,
                   remaining_quantity);
          if (status !== e.status)
            $error("status exp %0d got %0d", e.status, status);
          if (spread !== e.spread)
            $error("spread exp %0d got %0d", e.spread, spread);
          if (waiting_bids !== e.waiting_bids)
            $error("waiting_bids exp %0d got %0d", e.waiting_bids, waiting_bids);
          if (waiting_asks !== e.waiting_asks)
            $error("waiting_asks exp %0d got %0d", e.waiting_asks, waiting_asks);
          if (last !== e.last)
            $error("last exp %0d got %0d", e.last, last);
        end
      end
      if (push && !full)
        match_order(op_t'(op), side_t'(side), order_id, quantity, price);
    end
  end

endmodule

// File: tb/tb_top.sv
module tb_top;
  import lom_pkg::*;

  logic clk, rst, push, pop;
  logic op, side;
  logic [ID_W-1:0] order_id;
  logic [QTY_W-1:0] quantity;
  logic [PRICE_W-1:0] price;
  logic full, empty, kind, last;
  logic [QTY_W-1:0] fill_quantity, remaining_quantity;
  logic [PRICE_W-1:0] fill_price;
  logic [ID_W-1:0] resting_order_id;
  logic [1:0] status;
  logic signed [CNT_W-1:0] spread;
  logic [CNT_W-1:0] waiting_bids, waiting_asks;
  int errors, pending;
  bit hold_results;

  limit_order_matcher_unit dut (.*);

  lom_checker chk (.*);

  initial begin
    clk = 0;
    forever #10 clk = ~clk;
  end

  initial begin
    #40000000;
    $display("tb_top: done, errors");
    $finish;
  end

  // Result side: random pops, plus one long hold-off
  initial begin
    int gap;
    pop = 0;
    @(posedge clk iff !rst);
    forever begin
      if (hold_results) begin
        pop <= 0;
        repeat (400) @(posedge clk);
        hold_results = 0;
      end
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 15);
      if (gap > 0) begin
        pop <= 0;
        repeat (gap) @(posedge clk);
      end
      pop <= 1;
      @(posedge clk iff !empty);
    end
  end

  // Offer one transaction and wait for it to be taken
  task automatic send(input op_t o, input side_t s, input int id, input int q,
                      input int p, input bit gaps);
    int gap;
    gap = gaps ? $urandom_range(0, 15) : 0;
    if (gap > 0) begin
      push <= 0;
      repeat (gap) @(posedge clk);
    end
    push <= 1;
    op <= o;
    side <= s;
    order_id <= ID_W'(id);
    quantity <= QTY_W'(q);
    price <= PRICE_W'(p);
    @(posedge clk iff !full);
  endtask

  initial begin
    int id, q, p, mid;
    rst = 1;
    push = 0;
    op = 0;
    side = 0;
    order_id = 0;
    quantity = 0;
    price = 0;
    hold_results = 0;
    repeat (6) @(posedge clk);
    rst <= 0;
    @(posedge clk);
    // Directed: extremes, both operations, special cases
    send(OP_ADD, SIDE_BID, 0, 24'hFFFFFF, 0, 0);
    send(OP_ADD, SIDE_ASK, 1023, 24'hFFFFFF, 1023, 0);
    send(OP_ADD, SIDE_BID, 0, 5, 10, 0);          // id already live
    send(OP_CANCEL, SIDE_ASK, 500, 0, 0, 0);      // unknown id
    send(OP_ADD, SIDE_ASK, 2, 0, 5, 0);           // zero quantity
    send(OP_CANCEL, SIDE_BID, 0, 7, 3, 0);
    send(OP_CANCEL, SIDE_ASK, 1023, 0, 0, 0);
    // Fill limit: 70 small asks swept by one large bid
    for (int i = 0; i < 70; i++)
      send(OP_ADD, SIDE_ASK, 100 + i, 1, 200 + (i % 5), 0);
    send(OP_ADD, SIDE_BID, 300, 1000, 1023, 0);   // crossed book afterwards
    send(OP_ADD, SIDE_ASK, 301, 24'hFFFFFF, 0, 0);
    // Sender pause until every result is in
    push <= 0;
    @(posedge clk);
    wait (pending == 0);
    // Random phase; block fills while results are held off
    for (int n = 0; n < 290; n++) begin
      if (n == 100) hold_results = 1;
      if (n == 250) begin
        push <= 0;
        @(posedge clk);
        wait (pending == 0);
      end
      mid = 500 + $urandom_range(0, 40) - 20;
      id = ($urandom_range(0, 9) == 0) ? $urandom : $urandom_range(0, 63);
      q = ($urandom_range(0, 9) == 0) ? $urandom : $urandom_range(0, 60);
      p = ($urandom_range(0, 9) == 0) ? $urandom : mid + $urandom_range(0, 10) - 5;
      if ($urandom_range(0, 4) == 0)
        send(OP_CANCEL, side_t'($urandom), id, $urandom, $urandom, 1);
      else
        send(OP_ADD, side_t'($urandom), id, q, p, 1);
    end
    push <= 0;
    @(posedge clk);
    wait (pending == 0);
    repeat (500) @(posedge clk);
    if (errors == 0)
      $display("tb_top: done, clean");
    else
      $display("tb_top: done, errors");
    $finish;
  end

endmodule

// File: files.f
sv/lom_pkg.sv
sv/lom_fifo.sv
sv/lom_front.sv
sv/lom_engine.sv
sv/limit_order_matcher_unit.sv
tb/lom_checker.sv
tb/tb_top.sv
